FILE: hw/rtl/hla_pkg.sv
// shared types and codes for the hole list allocator
package hla_pkg;
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOFIT    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_UNKNOWN  = 3'd3;
  localparam logic [2:0] ST_DISABLED = 3'd4;

  localparam logic [1:0] CFG_POLICY  = 2'd0;
  localparam logic [1:0] CFG_REGION  = 2'd1;
  localparam logic [1:0] CFG_ENABLE  = 2'd2;

  // cell command broadcast each cycle
  typedef enum logic [3:0] {
    CMD_NONE  = 4'b0001,
    CMD_CLEAR = 4'b0010,
    CMD_WRITE = 4'b0100,
    CMD_KILL  = 4'b1000
  } hla_cmd_t;
endpackage

FILE: hw/rtl/hla_cell.sv
// one table entry: valid, offset, length, shift-out for scanning
module hla_cell #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  hla_pkg::hla_cmd_t       cmd,
  input  logic                    sel,
  input  logic                    rot,
  input  logic                    wr_valid,
  input  logic [OFFSET_BITS-1:0]  wr_off,
  input  logic [OFFSET_BITS:0]    wr_len,
  input  logic                    rst_valid,
  input  logic [OFFSET_BITS-1:0]  rst_off,
  input  logic [OFFSET_BITS:0]    rst_len,
  input  logic                    nb_valid,
  input  logic [OFFSET_BITS-1:0]  nb_off,
  input  logic [OFFSET_BITS:0]    nb_len,
  output logic                    valid,
  output logic [OFFSET_BITS-1:0]  off,
  output logic [OFFSET_BITS:0]    len
);
  import hla_pkg::*;
  logic                   valid_r, valid_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [OFFSET_BITS:0]   len_r, len_nxt;

  always_comb begin
    valid_nxt = valid_r;
    off_nxt   = off_r;
    len_nxt   = len_r;
    if (rot) begin
      valid_nxt = nb_valid;
      off_nxt   = nb_off;
      len_nxt   = nb_len;
    end
    unique case (cmd)
      CMD_CLEAR: begin
        valid_nxt = rst_valid;
        off_nxt   = rst_off;
        len_nxt   = rst_len;
      end
      CMD_WRITE: if (sel) begin
        valid_nxt = wr_valid;
        off_nxt   = wr_off;
        len_nxt   = wr_len;
      end
      CMD_KILL: if (sel) valid_nxt = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= rst_valid;
    else        valid_r <= valid_nxt;
    if (!rst_n) begin
      off_r <= rst_off;
      len_r <= rst_len;
    end else begin
      off_r <= off_nxt;
      len_r <= len_nxt;
    end
  end

  assign valid = valid_r;
  assign off   = off_r;
  assign len   = len_r;
endmodule

FILE: hw/rtl/hla_table.sv
// ring of cells; rotates one place per scan cycle so the head cell is examined
module hla_table #(
  parameter int ENTRIES     = 64,
  parameter int OFFSET_BITS = 16,
  parameter bit HOLES       = 1'b1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  hla_pkg::hla_cmd_t       cmd,
  input  logic                    rot,
  input  logic [$clog2(ENTRIES)-1:0] idx,
  input  logic                    wr_valid,
  input  logic [OFFSET_BITS-1:0]  wr_off,
  input  logic [OFFSET_BITS:0]    wr_len,
  input  logic [OFFSET_BITS:0]    region,
  output logic                    head_valid,
  output logic [OFFSET_BITS-1:0]  head_off,
  output logic [OFFSET_BITS:0]    head_len
);
  import hla_pkg::*;
  localparam int IW = $clog2(ENTRIES);
  logic                   v [ENTRIES];
  logic [OFFSET_BITS-1:0] o [ENTRIES];
  logic [OFFSET_BITS:0]   l [ENTRIES];

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    localparam int NB = (g + 1) % ENTRIES;
    hla_cell #(.OFFSET_BITS(OFFSET_BITS)) u_cell (
      .clk(clk), .rst_n(rst_n), .cmd(cmd),
      .sel(idx == IW'(g)), .rot(rot),
      .wr_valid(wr_valid), .wr_off(wr_off), .wr_len(wr_len),
      .rst_valid((g == 0) && HOLES && (region != '0)),
      .rst_off('0),
      .rst_len(region),
      .nb_valid(v[NB]), .nb_off(o[NB]), .nb_len(l[NB]),
      .valid(v[g]), .off(o[g]), .len(l[g])
    );
  end

  assign head_valid = v[0];
  assign head_off   = o[0];
  assign head_len   = l[0];
endmodule

FILE: hw/rtl/hole_list_allocator.sv
// top level: hole and block tables with scan sequencer
// Each table is scanned once, one entry per cycle, by rotating its ring of cells past
// the head cell, blocks first and then holes. S_DEC then decides and S_UPD updates; a
// successful free kills the block and any hole after it, then writes the merged hole.
// out_strobe is high for a single cycle, in S_OUT, and cannot be held; out_status and
// out_result_offset keep their values until the next decision. busy falls at the edge
// that ends the strobe cycle, and only then is a new item taken. After reset or a region
// write the hole table holds one hole covering the region (none if it is zero) and the
// block table is empty. Configuration is taken when busy is low.
module hole_list_allocator #(
  parameter int TABLE_ENTRIES = 64,
  parameter int OFFSET_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_kind,
  input  logic [OFFSET_BITS-1:0] in_request_words,
  input  logic [OFFSET_BITS-1:0] in_block_offset,
  output logic                   out_strobe,
  output logic [2:0]             out_status,
  output logic [OFFSET_BITS-1:0] out_result_offset,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data
);
  import hla_pkg::*;
  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int OB = OFFSET_BITS;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCANB = 6'b000010,
    S_SCANH = 6'b000100,
    S_DEC   = 6'b001000,
    S_UPD   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t        state_r;
  logic          policy_r, enabled_r;
  logic [OB:0]   region_r;
  logic          kind_r;
  logic [OB:0]   req_r;
  logic [OB-1:0] boff_r;
  logic [IW:0]   cnt_r;
  logic [IW-1:0] pos;
  // block scan results
  logic          bfree_f_r, bfound_r;
  logic [IW-1:0] bfree_r, bidx_r;
  logic [OB:0]   blen_r;
  // hole scan results
  logic          hfree_f_r, pick_f_r, aft_f_r, bef_f_r;
  logic [IW-1:0] hfree_r, pick_r, aft_r, bef_r;
  logic [OB-1:0] pick_off_r;
  logic [OB:0]   pick_len_r, aft_len_r, bef_len_r;
  logic [2:0]    st_r;
  logic [OB-1:0] res_r;
  logic          strobe_r;

  hla_cmd_t      hcmd, bcmd;
  logic          hrot, brot;
  logic [IW-1:0] hidx, bidx;
  logic          hwv, bwv;
  logic [OB-1:0] hwo, bwo;
  logic [OB:0]   hwl, bwl;
  logic          hv, bv;
  logic [OB-1:0] ho, bo;
  logic [OB:0]   hl, bl;
  logic          cfg_do;
  logic [1:0]    upd_r;
  logic [OB:0]   clr_len;

  assign pos = cnt_r[IW-1:0];
  assign cfg_ready = (state_r == S_IDLE);
  assign busy = (state_r != S_IDLE);
  assign cfg_do = cfg_valid && cfg_ready;

  // length of the single hole left by a clear
  assign clr_len = !rst_n ? (OB+1)'(65535) :
                   (cfg_do && cfg_index == CFG_REGION) ? (OB+1)'(cfg_data) : region_r;

  hla_table #(.ENTRIES(TABLE_ENTRIES), .OFFSET_BITS(OB), .HOLES(1'b1)) u_holes (
    .clk(clk), .rst_n(rst_n), .cmd(hcmd), .rot(hrot), .idx(hidx),
    .wr_valid(hwv), .wr_off(hwo), .wr_len(hwl), .region(clr_len),
    .head_valid(hv), .head_off(ho), .head_len(hl));
  hla_table #(.ENTRIES(TABLE_ENTRIES), .OFFSET_BITS(OB), .HOLES(1'b0)) u_blocks (
    .clk(clk), .rst_n(rst_n), .cmd(bcmd), .rot(brot), .idx(bidx),
    .wr_valid(bwv), .wr_off(bwo), .wr_len(bwl), .region(clr_len),
    .head_valid(bv), .head_off(bo), .head_len(bl));

  assign hrot = (state_r == S_SCANH);
  assign brot = (state_r == S_SCANB);

  logic          better;
  logic [OB:0]   h_end;
  logic [OB:0]   b_end;
  logic [OB:0]   sum;
  always_comb begin
    h_end = {1'b0, ho} + hl;
    b_end = {1'b0, boff_r} + blen_r;
    if (policy_r) better = (hl > pick_len_r) || (hl == pick_len_r && ho < pick_off_r);
    else          better = (hl < pick_len_r) || (hl == pick_len_r && ho < pick_off_r);
    sum = blen_r + aft_len_r;
  end

  // table writes in update cycles, and clears of both tables on a region write
  always_comb begin
    hcmd = CMD_NONE; bcmd = CMD_NONE;
    hidx = pick_r; bidx = bfree_r;
    hwv = 1'b1; hwo = '0; hwl = '0;
    bwv = 1'b1; bwo = '0; bwl = '0;
    if (cfg_do && cfg_index == CFG_REGION) begin
      hcmd = CMD_CLEAR; bcmd = CMD_CLEAR;
    end else if (state_r == S_UPD && st_r == ST_OK) begin
      if (!kind_r) begin
        bcmd = CMD_WRITE; bidx = bfree_r;
        bwo = pick_off_r; bwl = req_r;
        hcmd = CMD_WRITE; hidx = pick_r;
        hwo = pick_off_r + req_r[OB-1:0];
        hwl = pick_len_r - req_r;
        hwv = (pick_len_r != req_r);
      end else begin
        bcmd = CMD_KILL; bidx = bidx_r;
        if (upd_r == 2'd0) begin
          if (aft_f_r) begin
            hcmd = CMD_KILL; hidx = aft_r;
          end
        end else begin
          hcmd = CMD_WRITE;
          if (bef_f_r) begin
            hidx = bef_r; hwo = boff_r - bef_len_r[OB-1:0];
            hwl = bef_len_r + (aft_f_r ? sum : blen_r);
          end else begin
            hidx = aft_f_r ? aft_r : hfree_r;
            hwo = boff_r; hwl = aft_f_r ? sum : blen_r;
          end
          bcmd = CMD_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      policy_r  <= 1'b0;
      enabled_r <= 1'b1;
      region_r  <= (OB+1)'(65535);
      strobe_r  <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      if (cfg_do) begin
        case (cfg_index)
          CFG_POLICY: policy_r  <= cfg_data[0];
          CFG_REGION: region_r  <= (OB+1)'(cfg_data);
          CFG_ENABLE: enabled_r <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: if (start) begin
          kind_r <= in_kind;
          req_r  <= (OB+1)'(in_request_words);
          boff_r <= OB'(in_block_offset);
          cnt_r  <= '0;
          bfree_f_r <= 1'b0; bfound_r <= 1'b0;
          hfree_f_r <= 1'b0; pick_f_r <= 1'b0;
          aft_f_r <= 1'b0; bef_f_r <= 1'b0;
          state_r <= S_SCANB;
        end
        S_SCANB: begin
          if (!bv && !bfree_f_r) begin
            bfree_f_r <= 1'b1; bfree_r <= pos;
          end
          if (bv && !bfound_r && bo == boff_r) begin
            bfound_r <= 1'b1; bidx_r <= pos; blen_r <= bl;
          end
          cnt_r <= cnt_r + (IW+1)'(1);
          if (cnt_r == (IW+1)'(TABLE_ENTRIES - 1)) begin
            cnt_r <= '0; state_r <= S_SCANH;
          end
        end
        S_SCANH: begin
          if (!hv && !hfree_f_r) begin
            hfree_f_r <= 1'b1; hfree_r <= pos;
          end
          if (hv && hl >= req_r && (!pick_f_r || better)) begin
            pick_f_r <= 1'b1; pick_r <= pos; pick_off_r <= ho; pick_len_r <= hl;
          end
          if (hv && !aft_f_r && {1'b0, ho} == b_end) begin
            aft_f_r <= 1'b1; aft_r <= pos; aft_len_r <= hl;
          end
          if (hv && !bef_f_r && h_end == {1'b0, boff_r}) begin
            bef_f_r <= 1'b1; bef_r <= pos; bef_len_r <= hl;
          end
          cnt_r <= cnt_r + (IW+1)'(1);
          if (cnt_r == (IW+1)'(TABLE_ENTRIES - 1)) state_r <= S_DEC;
        end
        S_DEC: begin
          res_r <= '0;
          upd_r <= 2'd0;
          if (!enabled_r) st_r <= ST_DISABLED;
          else if (!kind_r) begin
            if (req_r == '0 || !pick_f_r) st_r <= ST_NOFIT;
            else if (!bfree_f_r) st_r <= ST_FULL;
            else begin
              st_r <= ST_OK; res_r <= pick_off_r;
            end
          end else begin
            if (!bfound_r) st_r <= ST_UNKNOWN;
            else if (!aft_f_r && !bef_f_r && !hfree_f_r) st_r <= ST_FULL;
            else begin
              st_r <= ST_OK; res_r <= boff_r;
            end
          end
          state_r <= S_UPD;
        end
        S_UPD: begin
          upd_r <= upd_r + 2'd1;
          if (kind_r == 1'b0 || upd_r == 2'd1 || st_r != ST_OK) begin
            state_r <= S_OUT; strobe_r <= 1'b1;
          end
        end
        S_OUT: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_strobe        = strobe_r;
  assign out_status        = st_r;
  assign out_result_offset = res_r;
endmodule

FILE: sim/tb.sv
// testbench for the hole list allocator: directed and random requests against a predictor
`timescale 1ns / 100ps

module tb;
  import hla_pkg::*;

  localparam int ENTRIES = 64;
  localparam int LATENCY = 2 * ENTRIES + 3;
  localparam int LIMIT = 1000000;
  localparam bit KIND_ALLOC = 1'b0;
  localparam bit KIND_FREE = 1'b1;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_kind;
  logic [15:0] in_request_words;
  logic [15:0] in_block_offset;
  logic        out_strobe;
  logic [2:0]  out_status;
  logic [15:0] out_result_offset;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] offset;
  } answer_t;

  typedef struct {
    bit used;
    int base;
    int len;
  } span_t;

  answer_t pending_answers[$];
  span_t   holes[ENTRIES];
  span_t   blocks[ENTRIES];
  bit      worst_fit;
  int      region;
  bit      active;
  bit      idle_on;
  int      cycles;
  int      errors;
  int      n_words;
  int      n_ok;
  int      n_refused;

  hole_list_allocator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_request_words(in_request_words),
    .in_block_offset(in_block_offset), .out_strobe(out_strobe),
    .out_status(out_status), .out_result_offset(out_result_offset),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_strobe) begin
      if (pending_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected word status %0d offset %0d", $time, out_status,
                 out_result_offset);
      end else begin
        want = pending_answers.pop_front();
        if (want.status == ST_OK) n_ok++;
        else n_refused++;
        if (out_status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
        end
        if (out_result_offset !== want.offset) begin
          errors++;
          $display("%0t: offset expected %0d actual %0d", $time, want.offset,
                   out_result_offset);
        end
      end
    end
  end

  function automatic void clear_spans();
    foreach (holes[i]) begin
      holes[i] = '{0, 0, 0};
      blocks[i] = '{0, 0, 0};
    end
    if (region != 0) holes[0] = '{1, 0, region};
  endfunction

  function automatic int first_unused(bit in_holes);
    for (int i = 0; i < ENTRIES; i++) begin
      if (in_holes ? !holes[i].used : !blocks[i].used) return i;
    end
    return -1;
  endfunction

  function automatic answer_t allocator_answer(bit kind, int req, int off);
    answer_t a;
    int pick, slot, blk, after, prior, len;
    bit better;
    a.status = ST_OK;
    a.offset = '0;
    pick = -1;
    slot = -1;
    blk = -1;
    after = -1;
    prior = -1;
    if (!active) begin
      a.status = ST_DISABLED;
    end else if (kind == KIND_ALLOC) begin
      if (req == 0) begin
        a.status = ST_NOFIT;
      end else begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (holes[i].used && holes[i].len >= req) begin
            if (pick < 0) begin
              pick = i;
            end else begin
              if (worst_fit)
                better = holes[i].len > holes[pick].len ||
                         (holes[i].len == holes[pick].len && holes[i].base < holes[pick].base);
              else
                better = holes[i].len < holes[pick].len ||
                         (holes[i].len == holes[pick].len && holes[i].base < holes[pick].base);
              if (better) pick = i;
            end
          end
        end
        slot = first_unused(0);
        if (pick < 0) begin
          a.status = ST_NOFIT;
        end else if (slot < 0) begin
          a.status = ST_FULL;
        end else begin
          a.offset = holes[pick].base[15:0];
          blocks[slot] = '{1, holes[pick].base, req};
          holes[pick].base = (holes[pick].base + req) & 16'hffff;
          holes[pick].len -= req;
          if (holes[pick].len == 0) holes[pick].used = 0;
        end
      end
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (blk < 0 && blocks[i].used && blocks[i].base == off) blk = i;
      end
      if (blk < 0) begin
        a.status = ST_UNKNOWN;
      end else begin
        len = blocks[blk].len;
        for (int i = 0; i < ENTRIES; i++) begin
          if (holes[i].used) begin
            if (after < 0 && holes[i].base == off + len) after = i;
            if (prior < 0 && holes[i].base + holes[i].len == off) prior = i;
          end
        end
        if (after < 0 && prior < 0) slot = first_unused(1);
        if (after < 0 && prior < 0 && slot < 0) begin
          a.status = ST_FULL;
        end else begin
          blocks[blk].used = 0;
          if (after >= 0) begin
            len += holes[after].len;
            holes[after].used = 0;
          end
          if (prior >= 0) begin
            holes[prior].len += len;
          end else begin
            if (slot < 0) slot = after;
            holes[slot] = '{1, off, len};
          end
          a.offset = off[15:0];
        end
      end
    end
    if (a.status != ST_OK) a.offset = '0;
    return a;
  endfunction

  task automatic wait_drained();
    while (pending_answers.size() != 0) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic send_word(bit kind, int req, int off);
    int gap;
    gap = idle_on ? $urandom_range(0, 14) : 0;
    repeat (gap + 1) @(negedge clk);
    start <= 1'b1;
    in_kind <= kind;
    in_request_words <= req[15:0];
    in_block_offset <= off[15:0];
    do @(posedge clk); while (busy);
    pending_answers.insert(pending_answers.size(), allocator_answer(kind, req, off));
    n_words++;
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_POLICY: worst_fit = val[0];
      CFG_REGION: begin
        region = val & 16'hffff;
        clear_spans();
      end
      CFG_ENABLE: active = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_word(KIND_ALLOC, 0, 0);
    send_word(KIND_ALLOC, 1, 0);
    send_word(KIND_ALLOC, 65535, 0);
    send_word(KIND_FREE, 0, 16'hffff);
    send_word(KIND_FREE, 0, 0);
    send_word(KIND_ALLOC, 65535, 0);
    send_word(KIND_FREE, 65535, 0);
  endtask

  task automatic test_disabled();
    send_word(KIND_ALLOC, 10, 0);
    write_reg(CFG_ENABLE, 0);
    send_word(KIND_ALLOC, 10, 0);
    send_word(KIND_FREE, 0, 0);
    write_reg(CFG_ENABLE, 1);
    send_word(KIND_FREE, 0, 0);
  endtask

  task automatic test_region_edges();
    write_reg(CFG_REGION, 0);
    send_word(KIND_ALLOC, 1, 0);
    write_reg(CFG_REGION, 1);
    send_word(KIND_ALLOC, 1, 0);
    send_word(KIND_ALLOC, 1, 0);
    write_reg(CFG_SPARE, 16'hffff);
    send_word(KIND_FREE, 0, 0);
    write_reg(CFG_REGION, 65535);
    send_word(KIND_ALLOC, 32768, 0);
    send_word(KIND_ALLOC, 32767, 0);
  endtask

  task automatic test_fit_policy();
    write_reg(CFG_REGION, 100);
    write_reg(CFG_POLICY, 1);
    send_word(KIND_ALLOC, 40, 0);
    send_word(KIND_ALLOC, 30, 0);
    send_word(KIND_FREE, 0, 0);
    send_word(KIND_ALLOC, 41, 0);
    send_word(KIND_ALLOC, 10, 0);
    write_reg(CFG_POLICY, 0);
    send_word(KIND_ALLOC, 10, 0);
    send_word(KIND_ALLOC, 25, 0);
    send_word(KIND_FREE, 40, 40);
  endtask

  task automatic test_block_table_full();
    write_reg(CFG_REGION, 1000);
    repeat (ENTRIES + 1) send_word(KIND_ALLOC, 1, 0);
    send_word(KIND_FREE, 0, 5);
    send_word(KIND_ALLOC, 2, 0);
  endtask

  task automatic test_random();
    int live[$];
    int r, sz, pick_region;
    for (int phase = 0; phase < 5; phase++) begin
      idle_on = (phase != 2);
      case (phase)
        0: pick_region = 200;
        1: pick_region = 65535;
        2: pick_region = 1000;
        3: pick_region = 64;
        default: pick_region = $urandom_range(1, 65535);
      endcase
      write_reg(CFG_POLICY, $urandom_range(0, 1));
      write_reg(CFG_REGION, pick_region);
      for (int n = 0; n < 100; n++) begin
        if (n == 50) wait_drained();
        live.delete();
        foreach (blocks[i]) if (blocks[i].used) live.insert(live.size(), blocks[i].base);
        r = $urandom_range(0, 99);
        if (r < 40 && live.size() != 0) begin
          send_word(KIND_FREE, $urandom_range(0, 65535), live[$urandom_range(0, live.size() - 1)]);
        end else if (r < 46) begin
          send_word(KIND_FREE, $urandom_range(0, 65535), $urandom_range(0, 65535));
        end else begin
          if (r < 90) sz = $urandom_range(1, (pick_region / 16 > 1) ? pick_region / 16 : 1);
          else sz = $urandom_range(0, 65535);
          send_word(KIND_ALLOC, sz, $urandom_range(0, 65535));
        end
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = 1'b0;
    in_request_words = '0;
    in_block_offset = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cycles = 0;
    errors = 0;
    n_words = 0;
    n_ok = 0;
    n_refused = 0;
    idle_on = 1'b1;
    worst_fit = 1'b0;
    region = 65535;
    active = 1'b1;
    clear_spans();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_state();
    test_disabled();
    test_region_edges();
    test_fit_policy();
    test_block_table_full();
    test_random();

    wait_drained();
    repeat (LATENCY) @(posedge clk);
    $display("%0d words sent: %0d granted or freed, %0d refused", n_words, n_ok, n_refused);
    $display("covered best and worst fit, region extremes, disable and full block table");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

FILE: files.f
hw/rtl/hla_pkg.sv
hw/rtl/hla_cell.sv
hw/rtl/hla_table.sv
hw/rtl/hole_list_allocator.sv
sim/tb.sv
